// ===== rtl/maf_pkg.sv =====
// Shared constants, widths and sequencer states for the moving average filter.
// Used by maf_div and moving_average_filter_core; no dependencies.

package maf_pkg;

  localparam int MAX_WINDOW = 256;
  localparam int SAMPLE_W   = 16;
  localparam int LEN_W      = 9;
  localparam int PTR_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W      = PTR_W + 1;
  // a full window of samples fits without overflow
  localparam int SUM_W      = SAMPLE_W + PTR_W;
  localparam int STEP_W     = $clog2(SUM_W + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADJ,
    ST_ADJ_RD,
    ST_ADD,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } maf_state_t;

endpackage

// ===== rtl/maf_div.sv =====
// Bit-serial restoring divider: unsigned dividend by unsigned divisor, one
// quotient bit per cycle. Depends on maf_pkg.

module maf_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [maf_pkg::SUM_W-1:0]  dividend,
  input  logic [maf_pkg::CNT_W-1:0]  divisor,
  output logic                       done,
  output logic [maf_pkg::SUM_W-1:0]  quotient
);
  import maf_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;
  logic [CNT_W-1:0]  rem_next;

  always_comb begin
    trial    = {rem, quo[SUM_W-1]};
    diff     = trial - {1'b0, dvs};
    ge       = (trial >= {1'b0, dvs});
    // remainder stays below divisor, so the top bit drops out
    rem_next = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(SUM_W);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[SUM_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/moving_average_filter_core.sv =====
// Boxcar moving average filter top level: sample ring, running-sum sequencer
// and output register. Depends on maf_pkg and maf_div.

// Each sample transaction returns the mean of the latest window_len samples of
// the current block (fewer during warm-up after block_start), truncated toward
// zero. For each accepted sample the running sum is first corrected one ring
// entry at a time through the single-port sample memory (ST_ADJ, ST_ADJ_RD):
// no entry during warm-up, one once the window is full and up to 256 after
// window_len changes mid-block. The new sample is then added and a bit-serial
// divider produces one quotient bit per cycle. The next sample is taken once
// the result sits in the output register, even if it has not been taken yet.
// window_len of 0 acts as 1, values above 256 act as 256; write it only while
// the filter is idle.

module moving_average_filter_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [maf_pkg::LEN_W-1:0]     cfg_wdata,     // window_len
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [maf_pkg::SAMPLE_W-1:0]  s_axis_tdata,  // [15:0] sample
  input  logic                          s_axis_tuser,  // [0] block_start
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [maf_pkg::SAMPLE_W-1:0]  m_axis_tdata   // [15:0] average
);
  import maf_pkg::*;

  maf_state_t state, state_next;

  logic [SAMPLE_W-1:0]     ring [MAX_WINDOW];
  logic [SAMPLE_W-1:0]     rd_data;

  logic [LEN_W-1:0]        win_len;
  logic signed [SUM_W-1:0] sum;
  logic [CNT_W-1:0]        cnt;
  logic [CNT_W-1:0]        fill;
  logic [CNT_W-1:0]        target;
  logic [PTR_W-1:0]        wp;
  logic [SAMPLE_W-1:0]     sample;
  logic                    sub_op;
  logic                    sum_neg;

  logic                    in_xact;
  logic [CNT_W-1:0]        fill_base;
  logic [CNT_W-1:0]        fill_next;
  logic [CNT_W-1:0]        len_eff;
  logic [CNT_W-1:0]        m_next;

  logic                    grow;
  logic [PTR_W-1:0]        rd_addr;
  logic                    rd_en;
  logic signed [SUM_W-1:0] alu_b;
  logic                    alu_sub;
  logic signed [SUM_W-1:0] alu_out;
  logic                    div_start;
  logic                    out_load;
  logic [SUM_W-1:0]        sum_mag;
  logic                    div_done;
  logic [SUM_W-1:0]        div_q;

  // window size for the incoming sample
  always_comb begin
    in_xact   = s_axis_tvalid && s_axis_tready;
    fill_base = s_axis_tuser ? '0 : fill;
    fill_next = (fill_base < CNT_W'(MAX_WINDOW)) ? fill_base + 1'b1 : fill_base;
    if (win_len == '0) begin
      len_eff = CNT_W'(1);
    end else if (win_len > LEN_W'(MAX_WINDOW)) begin
      len_eff = CNT_W'(MAX_WINDOW);
    end else begin
      len_eff = CNT_W'(win_len);
    end
    m_next = (fill_next < len_eff) ? fill_next : len_eff;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_xact) state_next = ST_ADJ;
      ST_ADJ:    state_next = (cnt == target) ? ST_ADD : ST_ADJ_RD;
      ST_ADJ_RD: state_next = ST_ADJ;
      ST_ADD:    state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_DIV;
      ST_DIV:    if (div_done) state_next = ST_DONE;
      ST_DONE:   if (out_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    grow          = (cnt < target);
    // older entry to pull in, or oldest entry to drop, relative to the old pointer
    rd_addr       = grow ? wp - cnt[PTR_W-1:0] - 1'b1 : wp - cnt[PTR_W-1:0];
    rd_en         = (state == ST_ADJ) && (cnt != target);
    alu_b         = (state == ST_ADD) ? SUM_W'(signed'(sample)) : SUM_W'(signed'(rd_data));
    alu_sub       = (state == ST_ADJ_RD) && sub_op;
    div_start     = (state == ST_LOAD);
    out_load      = (state == ST_DONE) && (!m_axis_tvalid || m_axis_tready);
    // sum is final during ST_LOAD, so take the sign straight from it
    sum_mag       = (sum < 0) ? SUM_W'(-sum) : SUM_W'(sum);
  end

  assign alu_out = alu_sub ? sum - alu_b : sum + alu_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      win_len <= LEN_W'(4);
      sum     <= '0;
      cnt     <= '0;
      fill    <= '0;
      wp      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        win_len <= cfg_wdata;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (in_xact) begin
            if (s_axis_tuser) begin
              sum <= '0;
              cnt <= '0;
              wp  <= '0;
            end
            fill <= fill_next;
          end
        end
        ST_ADJ_RD: begin
          sum <= alu_out;
          cnt <= sub_op ? cnt - 1'b1 : cnt + 1'b1;
        end
        ST_ADD: begin
          sum <= alu_out;
          cnt <= cnt + 1'b1;
          wp  <= wp + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xact) begin
      sample <= s_axis_tdata;
      target <= m_next - 1'b1;
    end
    if (rd_en) begin
      sub_op <= !grow;
    end
    if (state == ST_LOAD) begin
      sum_neg <= sum < 0;
    end
    if (out_load) begin
      m_axis_tdata <= sum_neg ? SAMPLE_W'(-div_q[SAMPLE_W-1:0])
                              : div_q[SAMPLE_W-1:0];
    end
  end

  // sample ring
  always_ff @(posedge clk) begin
    if (state == ST_ADD) begin
      ring[wp] <= sample;
    end
    if (rd_en) begin
      rd_data <= ring[rd_addr];
    end
  end

  maf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (cnt),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule
